/* rtl/pie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_pkg
// Shared types, constants and helpers of the palette index expander.
// ----------------------------------------------------------------------------
package pie_pkg;

    localparam int PAL_ENTRIES = 16;
    localparam int PAL_ADDR_W  = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam logic [4:0] PAL_LIMIT = 5'(PAL_ENTRIES);

    localparam int RES_W   = 11;
    localparam int LEVEL_W = 4;
    localparam logic [LEVEL_W-1:0] RES_MAX_LEVEL = 4'd10;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam logic CFG_INDEX_BITS  = 1'b0;
    localparam logic CFG_ALPHA_SHIFT = 1'b1;

    localparam int CFG_DATA_W = 5;

    typedef struct packed {
        logic        func;
        logic [3:0]  palette_slot;
        logic [31:0] palette_color;
        logic [7:0]  index_byte;
        logic [7:0]  alpha;
        logic        first_pixel;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        byte_taken;
    } out_item_t;

    typedef struct packed {
        logic       step;
        logic       first;
        logic [7:0] index_byte;
        logic [2:0] bits;
    } res_req_t;

    typedef struct packed {
        logic [3:0]         idx;
        logic               taken;
        logic [LEVEL_W-1:0] level;
    } res_rsp_t;

    function automatic logic [2:0] eff_bits(input logic [2:0] cfg);
        logic [2:0] r;
        if (cfg == 3'd0)
            r = 3'd1;
        else if (cfg > 3'd4)
            r = 3'd4;
        else
            r = cfg;
        return r;
    endfunction

    function automatic logic [3:0] idx_mask(input logic [2:0] bits);
        logic [3:0] m;
        unique case (bits)
            3'd1:    m = 4'b0001;
            3'd2:    m = 4'b0011;
            3'd3:    m = 4'b0111;
            default: m = 4'b1111;
        endcase
        return m;
    endfunction

endpackage

/* rtl/pie_reservoir.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_reservoir
// Bit reservoir that unpacks LSB-first palette indices from index bytes.
// ----------------------------------------------------------------------------
module pie_reservoir
    import pie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  res_req_t req,
    output res_rsp_t rsp
);

    logic [RES_W-1:0]   res_reg, res_next;
    logic [LEVEL_W-1:0] cnt_reg, cnt_next;

    logic [RES_W-1:0]   res0, res1;
    logic [LEVEL_W-1:0] cnt0, cnt1;
    logic               take;

    always_comb
    begin
        res0 = req.first ? '0 : res_reg;
        cnt0 = req.first ? '0 : cnt_reg;
        take = cnt0 < {1'b0, req.bits};
        res1 = res0;
        cnt1 = cnt0;
        if (take)
        begin
            res1 = res0 | (RES_W'(req.index_byte) << cnt0[1:0]);
            cnt1 = cnt0 + 4'd8;
        end
        res_next = res1 >> req.bits;
        cnt_next = cnt1 - {1'b0, req.bits};
    end

    assign rsp.idx   = res1[3:0] & idx_mask(req.bits);
    assign rsp.taken = take;
    assign rsp.level = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
            cnt_reg <= '0;
        end
        else if (req.step)
        begin
            res_reg <= res_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/pie_palette.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_palette
// Colour store with one write port and one read port.
// ----------------------------------------------------------------------------
module pie_palette
    import pie_pkg::*;
(
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  slot,
    input  logic [31:0] color,
    input  logic [3:0]  idx,
    output logic [31:0] entry
);

    logic [31:0] pal_reg [PAL_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we && ({1'b0, slot} < PAL_LIMIT))
            pal_reg[slot[PAL_ADDR_W-1:0]] <= color;
    end

    assign entry = ({1'b0, idx} < PAL_LIMIT) ? pal_reg[idx[PAL_ADDR_W-1:0]] : '0;

endmodule

/* rtl/palette_index_expand_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_index_expand_top
// Expands packed 1..4 bit palette indices into 32-bit pixels with alpha.
//
//   channel | direction | payload    | handshake
//   in      | input     | in_item_t  | in_valid / in_stall
//   out     | output    | out_item_t | out_valid / out_stall
//   cfg     | input     | cfg_data   | cfg_we, cfg_index
//
// Items are taken one per cycle while in_stall is low; a pixel passes the input
// register, then the result register, before it is offered on out.
// The reservoir update and palette read sit between the two registers.
// Reset clears valid flags and reservoir and sets index bits 4, alpha shift 24;
// the palette is undefined. in_stall rises only when the input register
// holds a pixel and the result register is full and stalled.
// ----------------------------------------------------------------------------
module palette_index_expand_top
    import pie_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [2:0]  index_bits_reg;
    logic [4:0]  alpha_shift_reg;

    logic        s1_valid_reg, s1_valid_next;
    in_item_t    s1_item_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg;

    logic        s1_pixel;
    logic        s1_adv;
    logic        in_accept;
    logic        out_load;
    res_req_t    res_req;
    res_rsp_t    res_rsp;
    logic [31:0] pal_entry;
    logic [31:0] alpha_field;

    assign s1_pixel  = s1_item_reg.func == FUNC_PIXEL;
    assign s1_adv    = s1_valid_reg && (!s1_pixel || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign out_load  = s1_adv && s1_pixel;

    assign res_req.step       = out_load;
    assign res_req.first      = s1_item_reg.first_pixel;
    assign res_req.index_byte = s1_item_reg.index_byte;
    assign res_req.bits       = eff_bits(index_bits_reg);

    pie_reservoir u_res (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (res_req),
        .rsp   (res_rsp)
    );

    pie_palette u_pal (
        .clk   (clk),
        .we    (s1_adv && (s1_item_reg.func == FUNC_WRITE)),
        .slot  (s1_item_reg.palette_slot),
        .color (s1_item_reg.palette_color),
        .idx   (res_rsp.idx),
        .entry (pal_entry)
    );

    assign alpha_field = 32'(s1_item_reg.alpha) << alpha_shift_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            index_bits_reg  <= 3'd4;
            alpha_shift_reg <= 5'd24;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[2:0];
                    CFG_ALPHA_SHIFT: alpha_shift_reg <= cfg_data[4:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_item_reg <= in_item;
        if (out_load)
        begin
            out_item_reg.pixel      <= pal_entry | alpha_field;
            out_item_reg.byte_taken <= res_rsp.taken;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("input item dropped while stalled");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_pixel && out_valid_reg && out_stall)
        else $error("stall without a blocked pixel");

    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        res_rsp.level <= RES_MAX_LEVEL)
        else $error("reservoir level out of range");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(out_load))
        else $error("result without a pixel item");
`endif

endmodule
